### rtl/core/scbr_pkg.sv
// shared types and constants for the sphere/box collision resolve block
// no dependencies

package scbr_pkg;

  // shape codes carried in a_kind and b_kind
  typedef enum logic {
    KIND_SPHERE = 1'b0,
    KIND_BOX    = 1'b1
  } scbr_kind_e;

  // decisions made in the front part, travelling with each job
  typedef struct packed {
    logic hit;
    logic moved;
    logic dot_neg;
  } scbr_flags_t;

  // depth of the job queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 4;

endpackage

### rtl/core/scbr_if.sv
// valid/ready channel interfaces for shape pairs and collision results
// no dependencies

interface scbr_in_if #(
  parameter int COORD_BITS = 16
);
  logic                      valid;
  logic                      ready;
  logic                      a_kind;
  logic [3*COORD_BITS-1:0]   a_first;
  logic [3*COORD_BITS-1:0]   a_second;
  logic                      b_kind;
  logic [3*COORD_BITS-1:0]   b_first;
  logic [3*COORD_BITS-1:0]   b_second;
  logic [3*COORD_BITS-1:0]   a_velocity;

  modport source (
    output valid, a_kind, a_first, a_second, b_kind, b_first, b_second, a_velocity,
    input  ready
  );
  modport sink (
    input  valid, a_kind, a_first, a_second, b_kind, b_first, b_second, a_velocity,
    output ready
  );
endinterface

interface scbr_out_if #(
  parameter int COORD_BITS = 16
);
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic                      moved;
  logic [3*COORD_BITS-1:0]   new_center;
  logic [3*COORD_BITS-1:0]   new_velocity;

  modport source (
    output valid, hit, moved, new_center, new_velocity,
    input  ready
  );
  modport sink (
    input  valid, hit, moved, new_center, new_velocity,
    output ready
  );
endinterface

### rtl/core/sphere_box_collision_resolve_top.sv
// Collision test and response for one sphere/box shape pair per beat. One pair
// is taken every cycle while results drain; the square-root pipeline (one root
// bit per stage) and the divider pipelines (one quotient bit per stage) in the
// back part lie on the path from an accepted input beat to its result.
// A four-entry job queue separates the front part from the back part, so input
// keeps flowing after the output stalls until the queue fills. Coordinates are
// signed fixed point with any number of fraction bits; results saturate to the
// coordinate range.
// depends on scbr_pkg, scbr_if, scbr_front and scbr_back

module sphere_box_collision_resolve_top import scbr_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  scbr_in_if.sink      in_if,
  scbr_out_if.source   out_if
);

  logic                         job_valid, job_ready;
  scbr_flags_t                  job_flags;
  logic [2*COORD_BITS:0]        job_dmag;
  logic signed [COORD_BITS:0]   job_rad;
  logic [2*COORD_BITS+1:0]      job_dsq;
  logic signed [COORD_BITS:0]   job_d [3];
  logic [COORD_BITS-1:0]        job_ctr [3];
  logic [COORD_BITS-1:0]        job_vel [3];

  scbr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_flags_o (job_flags),
    .job_dmag_o  (job_dmag),
    .job_rad_o   (job_rad),
    .job_dsq_o   (job_dsq),
    .job_d_o     (job_d),
    .job_ctr_o   (job_ctr),
    .job_vel_o   (job_vel)
  );

  scbr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_flags_i (job_flags),
    .job_dmag_i  (job_dmag),
    .job_rad_i   (job_rad),
    .job_dsq_i   (job_dsq),
    .job_d_i     (job_d),
    .job_ctr_i   (job_ctr),
    .job_vel_i   (job_vel),
    .out_if      (out_if)
  );

endmodule

### rtl/core/scbr_isqrt.sv
// pipelined integer square root, one root bit per stage, floor result
// stand-alone, carries a side word alongside the operand

module scbr_isqrt #(
  parameter int NW = 34,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NW-1:0]   num_i,
  input  logic [SW-1:0]   side_i,
  output logic [NW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);

  localparam int RW = NW / 2;

  logic [NW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    localparam int B = RW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [SW-1:0] side_in;
    logic [NW:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
    assign trial = ((NW+1)'(root_in) << (B + 1)) + ((NW+1)'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        if ({1'b0, rem_in} >= trial) begin
          rem_q[k]  <= rem_in - trial[NW-1:0];
          root_q[k] <= root_in | (RW'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[RW-1];
  assign side_o = side_q[RW-1];

endmodule

### rtl/core/scbr_div.sv
// pipelined restoring divider, three lanes over one shared divisor
// one quotient bit per stage; stand-alone, carries a side word

module scbr_div #(
  parameter int DW = 17,
  parameter int QB = 19,
  parameter int SW = 1
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [DW+QB-1:0]   num_i [3],
  input  logic [DW-1:0]      den_i,
  input  logic [SW-1:0]      side_i,
  output logic [QB-1:0]      quo_o [3],
  output logic [SW-1:0]      side_o
);

  localparam int NW = DW + QB;

  logic [NW-1:0] rem_q  [QB][3];
  logic [QB-1:0] quo_q  [QB][3];
  logic [DW-1:0] den_q  [QB];
  logic [SW-1:0] side_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int B = QB - 1 - k;
    logic [NW-1:0] rem_in [3];
    logic [QB-1:0] quo_in [3];
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [NW-1:0] sub;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (k == 0) begin
          rem_in[l] = num_i[l];
          quo_in[l] = '0;
        end else begin
          rem_in[l] = rem_q[(k == 0) ? 0 : k-1][l];
          quo_in[l] = quo_q[(k == 0) ? 0 : k-1][l];
        end
      end
    end

    if (k == 0) begin : g_first
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign sub = NW'(den_in) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= sub) begin
            rem_q[k][l] <= rem_in[l] - sub;
            quo_q[k][l] <= quo_in[l] | (QB'(1) << B);
          end else begin
            rem_q[k][l] <= rem_in[l];
            quo_q[k][l] <= quo_in[l];
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) quo_o[l] = quo_q[QB-1][l];
  end
  assign side_o = side_q[QB-1];

endmodule

### rtl/core/scbr_front.sv
// front part: takes shape pairs, works out offsets, squares and overlap
// depends on scbr_pkg and scbr_in_if

module scbr_front import scbr_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  scbr_in_if.sink                       in_if,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output scbr_flags_t                   job_flags_o,
  output logic [2*COORD_BITS:0]         job_dmag_o,
  output logic signed [COORD_BITS:0]    job_rad_o,
  output logic [2*COORD_BITS+1:0]       job_dsq_o,
  output logic signed [COORD_BITS:0]    job_d_o [3],
  output logic [COORD_BITS-1:0]         job_ctr_o [3],
  output logic [COORD_BITS-1:0]         job_vel_o [3]
);

  localparam int C = COORD_BITS;

  logic f_en;
  logic a_box, b_box, both_sph, both_box;
  logic signed [C-1:0] a1 [3], a2 [3], b1 [3], b2 [3];
  logic signed [C-1:0] sc [3], bmin [3], bmax [3], lo_clip [3], clip [3];
  logic signed [C-1:0] sr;
  logic signed [C:0]   d_d [3];
  logic signed [C:0]   rad_d;
  logic                ovl_d;

  logic                f1_vld_q, f2_vld_q;
  logic                f1_abox_q, f1_both_q, f1_ovl_q;
  logic signed [C:0]   f1_d_q [3];
  logic signed [C:0]   f1_rad_q;
  logic [C-1:0]        f1_ctr_q [3];
  logic signed [C-1:0] f1_vel_q [3];

  logic                f2_abox_q, f2_both_q, f2_ovl_q;
  logic [2*C+1:0]      f2_sq_q [3];
  logic [2*C+1:0]      f2_rad2_q;
  logic signed [2*C:0] f2_vd_q [3];
  logic signed [C:0]   f2_d_q [3];
  logic signed [C:0]   f2_rad_q;
  logic [C-1:0]        f2_ctr_q [3];
  logic signed [C-1:0] f2_vel_q [3];

  logic [2*C+1:0]      dsq;
  logic signed [2*C+2:0] dot, dabs;
  logic                hit;

  assign f_en        = !f2_vld_q || job_ready_i;
  assign in_if.ready = f_en;

  assign a_box    = (scbr_kind_e'(in_if.a_kind) == KIND_BOX);
  assign b_box    = (scbr_kind_e'(in_if.b_kind) == KIND_BOX);
  assign both_sph = !a_box && !b_box;
  assign both_box = a_box && b_box;

  // offsets from B (or the closest box point) to the sphere centre
  always_comb begin
    ovl_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      a1[i] = in_if.a_first[i*C +: C];
      a2[i] = in_if.a_second[i*C +: C];
      b1[i] = in_if.b_first[i*C +: C];
      b2[i] = in_if.b_second[i*C +: C];
      sc[i]   = a_box ? b1[i] : a1[i];
      bmin[i] = a_box ? a1[i] : b1[i];
      bmax[i] = a_box ? a2[i] : b2[i];
      lo_clip[i] = (sc[i] < bmax[i]) ? sc[i] : bmax[i];
      clip[i]    = (lo_clip[i] > bmin[i]) ? lo_clip[i] : bmin[i];
      if (both_sph) begin
        d_d[i] = {a1[i][C-1], a1[i]} - {b1[i][C-1], b1[i]};
      end else begin
        d_d[i] = {sc[i][C-1], sc[i]} - {clip[i][C-1], clip[i]};
      end
      if (!((a1[i] <= b2[i]) && (a2[i] >= b1[i]))) ovl_d = 1'b0;
    end
    sr = a_box ? b2[0] : a2[0];
    if (both_sph) begin
      rad_d = {a2[0][C-1], a2[0]} + {b2[0][C-1], b2[0]};
    end else begin
      rad_d = {sr[C-1], sr};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (f_en) begin
      f1_vld_q <= in_if.valid;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_en) begin
      f1_abox_q <= a_box;
      f1_both_q <= both_box;
      f1_ovl_q  <= ovl_d;
      f1_rad_q  <= rad_d;
      for (int i = 0; i < 3; i++) begin
        f1_d_q[i]   <= d_d[i];
        f1_ctr_q[i] <= a_box ? '0 : a1[i];
        f1_vel_q[i] <= in_if.a_velocity[i*C +: C];
      end
      f2_abox_q <= f1_abox_q;
      f2_both_q <= f1_both_q;
      f2_ovl_q  <= f1_ovl_q;
      f2_rad_q  <= f1_rad_q;
      f2_rad2_q <= f1_rad_q * f1_rad_q;
      for (int i = 0; i < 3; i++) begin
        f2_sq_q[i]  <= f1_d_q[i] * f1_d_q[i];
        f2_vd_q[i]  <= f1_vel_q[i] * f1_d_q[i];
        f2_d_q[i]   <= f1_d_q[i];
        f2_ctr_q[i] <= f1_ctr_q[i];
        f2_vel_q[i] <= f1_vel_q[i];
      end
    end
  end

  always_comb begin
    dsq  = f2_sq_q[0] + f2_sq_q[1] + f2_sq_q[2];
    dot  = f2_vd_q[0] + f2_vd_q[1] + f2_vd_q[2];
    dabs = dot[2*C+2] ? -dot : dot;
    hit  = f2_both_q ? f2_ovl_q : (dsq < f2_rad2_q);
    job_flags_o.hit     = hit;
    job_flags_o.moved   = !f2_abox_q && hit && (dsq != '0) && (f2_rad_q > 0);
    job_flags_o.dot_neg = dot[2*C+2];
  end

  assign job_valid_o = f2_vld_q;
  assign job_dmag_o  = dabs[2*C:0];
  assign job_rad_o   = f2_rad_q;
  assign job_dsq_o   = dsq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      job_d_o[i]   = f2_d_q[i];
      job_ctr_o[i] = f2_ctr_q[i];
      job_vel_o[i] = f2_vel_q[i];
    end
  end

  a_moved_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job_flags_o.moved |-> job_flags_o.hit && !f2_abox_q)
    else $error("front: correction flagged without overlap");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !f_en |=> $stable(f1_vld_q) && $stable(f2_vld_q))
    else $error("front: pipeline moved while stalled");

  a_moved_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job_flags_o.moved |-> (job_dsq_o != '0) && (job_rad_o > 0))
    else $error("front: correction flagged at zero distance or radius");

endmodule

### rtl/core/scbr_back.sv
// back part: job queue, square root, products, dividers, saturating update
// depends on scbr_pkg, scbr_out_if, scbr_isqrt and scbr_div

module scbr_back import scbr_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  input  scbr_flags_t                   job_flags_i,
  input  logic [2*COORD_BITS:0]         job_dmag_i,
  input  logic signed [COORD_BITS:0]    job_rad_i,
  input  logic [2*COORD_BITS+1:0]       job_dsq_i,
  input  logic signed [COORD_BITS:0]    job_d_i [3],
  input  logic [COORD_BITS-1:0]         job_ctr_i [3],
  input  logic [COORD_BITS-1:0]         job_vel_i [3],
  scbr_out_if.source                    out_if
);

  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;
  localparam int SQW = 2 * C + 2;
  localparam int DMW = 2 * C + 1;
  localparam int RW  = SQW / 2;
  localparam int QB  = C + 3;
  localparam int N1W = RW + QB;
  localparam int N2W = SQW + QB;
  localparam int L   = RW + QB + 2;
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW1 = 3 * C + 5;
  localparam int SW2 = 3 * C + 1;
  localparam int OW  = C + 5;
  localparam logic signed [OW-1:0] CMAX = OW'((1 << (C - 1)) - 1);
  localparam logic signed [OW-1:0] CMIN = ~CMAX;

  typedef struct packed {
    scbr_flags_t          flags;
    logic [DMW-1:0]       dmag;
    logic [DW-1:0]        rad;
    logic [SQW-1:0]       dsq;
    logic [2:0][DW-1:0]   d;
    logic [2:0][C-1:0]    ctr;
    logic [2:0][C-1:0]    vel;
  } job_t;

  function automatic logic [C-1:0] sat_c(input logic signed [OW-1:0] x);
    logic [C-1:0] r;
    if (x > CMAX) begin
      r = CMAX[C-1:0];
    end else if (x < CMIN) begin
      r = CMIN[C-1:0];
    end else begin
      r = x[C-1:0];
    end
    return r;
  endfunction

  logic          bk_en, push, pop;
  logic [L-1:0]  vld_q;
  job_t          q_mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  job_t          wr_job, head;

  logic [RW-1:0]           sq_root;
  logic [$bits(job_t)-1:0] sq_side;
  job_t                    sq_job;

  logic signed [DW:0]  pen_s;
  logic [DW-1:0]       pen_m;
  logic [DW-1:0]       dab [3];
  logic [2*DW-1:0]     prod1 [3];
  logic [DW+DMW-1:0]   prod2 [3];
  logic [N1W-1:0]      n1_d [3], n1_q [3];
  logic [N2W-1:0]      n2_d [3], n2_q [3];
  logic [RW-1:0]       dist_q;
  logic [SQW-1:0]      dsq_q;
  logic [SW1-1:0]      side1_q, side1_o;
  logic [SW2-1:0]      side2_q, side2_o;
  logic [QB-1:0]       q1 [3], q2 [3];

  logic                fin_hit, fin_moved, fin_fixv;
  logic [2:0]          fin_dneg;
  logic [3*C-1:0]      fin_ctr, fin_vel, nc_d, nv_d;
  logic signed [OW-1:0] c_ext, v_ext, q1_e, q2_e;

  logic                out_hit_q, out_moved_q;
  logic [3*C-1:0]      out_ctr_q, out_vel_q;

  // job queue
  assign job_ready_o = (cnt_q != CW'(QUEUE_DEPTH));
  assign push        = job_valid_i && job_ready_o;
  assign bk_en       = !vld_q[L-1] || out_if.ready;
  assign pop         = bk_en && (cnt_q != '0);
  assign head        = q_mem[rd_ptr_q];

  always_comb begin
    wr_job.flags = job_flags_i;
    wr_job.dmag  = job_dmag_i;
    wr_job.rad   = job_rad_i;
    wr_job.dsq   = job_dsq_i;
    for (int i = 0; i < 3; i++) begin
      wr_job.d[i]   = job_d_i[i];
      wr_job.ctr[i] = job_ctr_i[i];
      wr_job.vel[i] = job_vel_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= wr_job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      vld_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + CW'(push) - CW'(pop);
      if (bk_en) vld_q <= {vld_q[L-2:0], pop};
    end
  end

  scbr_isqrt #(
    .NW (SQW),
    .SW ($bits(job_t))
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (bk_en),
    .num_i  (head.dsq),
    .side_i (head),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  assign sq_job = sq_side;

  // penetration depth and the two numerators, with half the divisor for rounding
  always_comb begin
    pen_s = {sq_job.rad[DW-1], sq_job.rad} - {1'b0, sq_root};
    pen_m = pen_s[DW-1:0];
    for (int i = 0; i < 3; i++) begin
      dab[i]   = sq_job.d[i][DW-1] ? (~sq_job.d[i] + 1'b1) : sq_job.d[i];
      prod1[i] = dab[i] * pen_m;
      prod2[i] = dab[i] * sq_job.dmag;
      n1_d[i]  = N1W'(prod1[i]) + N1W'(sq_root >> 1);
      n2_d[i]  = N2W'(prod2[i]) + N2W'(sq_job.dsq >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (bk_en) begin
      for (int i = 0; i < 3; i++) begin
        n1_q[i] <= n1_d[i];
        n2_q[i] <= n2_d[i];
      end
      dist_q  <= sq_root;
      dsq_q   <= sq_job.dsq;
      side1_q <= {sq_job.flags.hit, sq_job.flags.moved,
                  sq_job.d[2][DW-1], sq_job.d[1][DW-1], sq_job.d[0][DW-1], sq_job.ctr};
      side2_q <= {sq_job.flags.moved && sq_job.flags.dot_neg, sq_job.vel};
    end
  end

  scbr_div #(
    .DW (RW),
    .QB (QB),
    .SW (SW1)
  ) u_div_ctr (
    .clk_i  (clk_i),
    .en_i   (bk_en),
    .num_i  (n1_q),
    .den_i  (dist_q),
    .side_i (side1_q),
    .quo_o  (q1),
    .side_o (side1_o)
  );

  scbr_div #(
    .DW (SQW),
    .QB (QB),
    .SW (SW2)
  ) u_div_vel (
    .clk_i  (clk_i),
    .en_i   (bk_en),
    .num_i  (n2_q),
    .den_i  (dsq_q),
    .side_i (side2_q),
    .quo_o  (q2),
    .side_o (side2_o)
  );

  // both corrections move along the offset sign: subtract when d is negative
  always_comb begin
    fin_hit   = side1_o[SW1-1];
    fin_moved = side1_o[SW1-2];
    fin_dneg  = side1_o[SW1-3 -: 3];
    fin_ctr   = side1_o[3*C-1:0];
    fin_fixv  = side2_o[SW2-1];
    fin_vel   = side2_o[3*C-1:0];
    nc_d      = fin_ctr;
    nv_d      = fin_vel;
    for (int i = 0; i < 3; i++) begin
      c_ext = OW'($signed(fin_ctr[i*C +: C]));
      v_ext = OW'($signed(fin_vel[i*C +: C]));
      q1_e  = OW'(q1[i]);
      q2_e  = OW'(q2[i]);
      if (fin_moved) begin
        nc_d[i*C +: C] = sat_c(fin_dneg[i] ? (c_ext - q1_e) : (c_ext + q1_e));
      end
      if (fin_fixv) begin
        nv_d[i*C +: C] = sat_c(fin_dneg[i] ? (v_ext - q2_e) : (v_ext + q2_e));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bk_en) begin
      out_hit_q   <= fin_hit;
      out_moved_q <= fin_moved;
      out_ctr_q   <= nc_d;
      out_vel_q   <= nv_d;
    end
  end

  assign out_if.valid        = vld_q[L-1];
  assign out_if.hit          = out_hit_q;
  assign out_if.moved        = out_moved_q;
  assign out_if.new_center   = out_ctr_q;
  assign out_if.new_velocity = out_vel_q;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("back: job queue overfilled");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bk_en |=> $stable(vld_q))
    else $error("back: pipeline moved while result stalled");

  a_moved_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.moved |-> out_if.hit)
    else $error("back: centre moved without overlap");

endmodule

### bench/scbr_tb_if.sv
`timescale 1ns / 100ps
// bench-side note: channel interfaces come from the rtl file scbr_if.sv
// this file holds the shared bench constants only; no dependencies

package scbr_tb_pkg;
  localparam int CB = 16;
  localparam int PW = 3 * CB;
endpackage

### bench/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for sphere_box_collision_resolve_top: directed and random shape pairs,
// a clocked driver and monitor, and an in-bench predictor of hit, correction and velocity
// depends on scbr_pkg, scbr_if, scbr_tb_pkg and the rtl top

module testbench;
  import scbr_pkg::*;
  import scbr_tb_pkg::*;

  typedef struct packed {
    scbr_kind_e      a_kind;
    logic [PW-1:0]   a_first;
    logic [PW-1:0]   a_second;
    scbr_kind_e      b_kind;
    logic [PW-1:0]   b_first;
    logic [PW-1:0]   b_second;
    logic [PW-1:0]   a_velocity;
  } pair_t;

  typedef struct packed {
    logic          hit;
    logic          moved;
    logic [PW-1:0] new_center;
    logic [PW-1:0] new_velocity;
  } response_t;

  localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam int     LATENCY = 2 * CB + 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  scbr_in_if  #(.COORD_BITS(CB)) in_if ();
  scbr_out_if #(.COORD_BITS(CB)) out_if ();

  sphere_box_collision_resolve_top #(.COORD_BITS(CB)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pair_t     pending_pairs[$];
  response_t expected_responses[$];
  int        error_count = 0;

  function automatic longint coord_of(logic [PW-1:0] p, int axis);
    logic signed [CB-1:0] v;
    v = p[axis*CB +: CB];
    return longint'(v);
  endfunction

  function automatic longint clip(longint x);
    if (x > CMAX) return CMAX;
    if (x < CMIN) return CMIN;
    return x;
  endfunction

  function automatic longint isqrt_floor(longint n);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= n) r += 64'sd1 <<< b;
    return r;
  endfunction

  // round half away from zero of a*b/c, c > 0
  function automatic longint scaled_round(longint a, longint b, longint c);
    logic signed [127:0] num, mag, q;
    num = 128'(a) * 128'(b);
    mag = (num < 0) ? -num : num;
    q = (mag + 128'(c / 2)) / 128'(c);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic response_t predict_collision(pair_t p);
    response_t r;
    longint a1[3], a2[3], b1[3], b2[3], v[3], d[3], c[3];
    longint rad, dsq, dot, root_len, pen, sc, lo, hi, m;
    bit hit, moved;
    rad = 0; dsq = 0; dot = 0; hit = 0; moved = 0;
    for (int i = 0; i < 3; i++) begin
      a1[i] = coord_of(p.a_first, i);  a2[i] = coord_of(p.a_second, i);
      b1[i] = coord_of(p.b_first, i);  b2[i] = coord_of(p.b_second, i);
      v[i]  = coord_of(p.a_velocity, i);
    end
    if (p.a_kind == KIND_BOX && p.b_kind == KIND_BOX) begin
      hit = 1;
      for (int i = 0; i < 3; i++)
        if (!(a1[i] <= b2[i] && a2[i] >= b1[i])) hit = 0;
    end else begin
      rad = (p.a_kind == KIND_SPHERE) ? a2[0] : b2[0];
      for (int i = 0; i < 3; i++) begin
        if (p.a_kind == KIND_SPHERE && p.b_kind == KIND_SPHERE) begin
          d[i] = a1[i] - b1[i];
        end else begin
          sc = (p.a_kind == KIND_SPHERE) ? a1[i] : b1[i];
          lo = (p.a_kind == KIND_SPHERE) ? b1[i] : a1[i];
          hi = (p.a_kind == KIND_SPHERE) ? b2[i] : a2[i];
          m = (sc < hi) ? sc : hi;
          d[i] = sc - ((m > lo) ? m : lo);
        end
        dsq += d[i] * d[i];
      end
      if (p.a_kind == KIND_SPHERE && p.b_kind == KIND_SPHERE) rad = a2[0] + b2[0];
      hit = dsq < rad * rad;
    end
    for (int i = 0; i < 3; i++) c[i] = (p.a_kind == KIND_SPHERE) ? a1[i] : 0;
    if (p.a_kind == KIND_SPHERE && hit && dsq > 0 && rad > 0) begin
      root_len = isqrt_floor(dsq);
      pen = rad - root_len;
      moved = 1;
      for (int i = 0; i < 3; i++) begin
        c[i] = clip(a1[i] + scaled_round(d[i], pen, root_len));
        dot += v[i] * d[i];
      end
      if (dot < 0)
        for (int i = 0; i < 3; i++) v[i] = clip(v[i] - scaled_round(d[i], dot, dsq));
    end
    r.hit = hit;
    r.moved = moved;
    for (int i = 0; i < 3; i++) begin
      r.new_center[i*CB +: CB]   = c[i][CB-1:0];
      r.new_velocity[i*CB +: CB] = v[i][CB-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [PW-1:0] got, logic [PW-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // driver: one pair per beat, random gap after each
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_gap <= 0;
    end else if (in_if.valid && !in_if.ready) begin
      // hold the beat
    end else begin
      if (in_if.valid) expected_responses.push_back(predict_collision(pair_t'{
        scbr_kind_e'(in_if.a_kind), in_if.a_first, in_if.a_second,
        scbr_kind_e'(in_if.b_kind), in_if.b_first, in_if.b_second, in_if.a_velocity}));
      if (send_gap > 0 || pending_pairs.size() == 0) begin
        in_if.valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        pair_t p;
        p = pending_pairs.pop_front();
        in_if.valid      <= 1'b1;
        in_if.a_kind     <= p.a_kind;
        in_if.a_first    <= p.a_first;
        in_if.a_second   <= p.a_second;
        in_if.b_kind     <= p.b_kind;
        in_if.b_first    <= p.b_first;
        in_if.b_second   <= p.b_second;
        in_if.a_velocity <= p.a_velocity;
        send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
      end
    end
  end

  // monitor: random back-pressure, compare each beat with the oldest prediction
  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
        if (expected_responses.size() == 0) begin
          report_mismatch("unexpected beat", out_if.new_center, '0);
        end else begin
          response_t w;
          w = expected_responses.pop_front();
          if (out_if.hit !== w.hit) report_mismatch("hit", PW'(out_if.hit), PW'(w.hit));
          if (out_if.moved !== w.moved)
            report_mismatch("moved", PW'(out_if.moved), PW'(w.moved));
          if (out_if.new_center !== w.new_center)
            report_mismatch("new_center", out_if.new_center, w.new_center);
          if (out_if.new_velocity !== w.new_velocity)
            report_mismatch("new_velocity", out_if.new_velocity, w.new_velocity);
        end
        stall_left <= (gap > 0) ? gap - 1 : 0;
        out_if.ready <= (gap == 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic logic [PW-1:0] pack_xyz(longint x, longint y, longint z);
    return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
  endfunction

  function automatic logic [PW-1:0] rand_xyz(int span);
    return pack_xyz(longint'($urandom_range(0, 2 * span)) - span,
                    longint'($urandom_range(0, 2 * span)) - span,
                    longint'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [PW-1:0] rand_wide();
    return PW'({$urandom(), $urandom()});
  endfunction

  function automatic pair_t shaped_pair(scbr_kind_e ak, scbr_kind_e bk, int span);
    pair_t p;
    longint lo;
    p.a_kind = ak;
    p.b_kind = bk;
    p.a_velocity = ($urandom_range(0, 7) == 0) ? rand_wide() : rand_xyz(2000);
    p.a_first = rand_xyz(span);
    p.b_first = rand_xyz(span);
    if (ak == KIND_SPHERE) begin
      p.a_second = rand_wide();
      p.a_second[CB-1:0] = CB'($urandom_range(0, span));
    end else begin
      for (int i = 0; i < 3; i++) begin
        lo = coord_of(p.a_first, i);
        p.a_second[i*CB +: CB] = CB'(clip(lo + longint'($urandom_range(0, span))));
      end
    end
    if (bk == KIND_SPHERE) begin
      p.b_second = rand_wide();
      p.b_second[CB-1:0] = CB'($urandom_range(0, span));
    end else begin
      for (int i = 0; i < 3; i++) begin
        lo = coord_of(p.b_first, i);
        p.b_second[i*CB +: CB] = CB'(clip(lo + longint'($urandom_range(0, span))));
      end
    end
    return p;
  endfunction

  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_if.valid || expected_responses.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    pair_t p;
    in_if.valid = 1'b0;
    in_if.a_kind = 1'b0;   in_if.b_kind = 1'b0;
    in_if.a_first = '0;    in_if.a_second = '0;
    in_if.b_first = '0;    in_if.b_second = '0;
    in_if.a_velocity = '0;
    out_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: concentric spheres, touching, penetrating, inward and outward velocity
    pending_pairs.push_back('{KIND_SPHERE, pack_xyz(0, 0, 0), pack_xyz(256, 0, 0),
        KIND_SPHERE, pack_xyz(0, 0, 0), pack_xyz(256, 0, 0), pack_xyz(5, 5, 5)});
    pending_pairs.push_back('{KIND_SPHERE, pack_xyz(512, 0, 0), pack_xyz(256, 0, 0),
        KIND_SPHERE, pack_xyz(0, 0, 0), pack_xyz(256, 0, 0), pack_xyz(-9, 0, 0)});
    pending_pairs.push_back('{KIND_SPHERE, pack_xyz(100, 30, -20), pack_xyz(256, 0, 0),
        KIND_SPHERE, pack_xyz(0, 0, 0), pack_xyz(256, 0, 0), pack_xyz(-300, 40, 7)});
    pending_pairs.push_back('{KIND_SPHERE, pack_xyz(100, 30, -20), pack_xyz(256, 0, 0),
        KIND_SPHERE, pack_xyz(0, 0, 0), pack_xyz(256, 0, 0), pack_xyz(300, 40, 7)});
    // negative radii: squared in the test, no correction
    pending_pairs.push_back('{KIND_SPHERE, pack_xyz(10, 0, 0), pack_xyz(-300, 0, 0),
        KIND_SPHERE, pack_xyz(0, 0, 0), pack_xyz(-20, 0, 0), pack_xyz(-1, 0, 0)});
    // saturation at the range ends
    pending_pairs.push_back('{KIND_SPHERE, pack_xyz(CMAX, CMIN, CMAX), pack_xyz(CMAX, 0, 0),
        KIND_SPHERE, pack_xyz(CMIN, CMAX, CMIN), pack_xyz(CMAX, 0, 0),
        pack_xyz(CMIN, CMAX, CMIN)});
    pending_pairs.push_back('{KIND_SPHERE, pack_xyz(CMAX, CMAX, CMAX), pack_xyz(CMAX, 0, 0),
        KIND_SPHERE, pack_xyz(CMAX - 1, CMAX, CMAX), pack_xyz(CMAX, 0, 0),
        pack_xyz(CMIN, CMIN, CMIN)});
    // sphere against box: outside, inside (zero distance), inverted box
    pending_pairs.push_back('{KIND_SPHERE, pack_xyz(300, 50, 50), pack_xyz(128, 0, 0),
        KIND_BOX, pack_xyz(0, 0, 0), pack_xyz(256, 256, 256), pack_xyz(-50, 3, 0)});
    pending_pairs.push_back('{KIND_SPHERE, pack_xyz(100, 50, 50), pack_xyz(128, 0, 0),
        KIND_BOX, pack_xyz(0, 0, 0), pack_xyz(256, 256, 256), pack_xyz(-50, 3, 0)});
    pending_pairs.push_back('{KIND_SPHERE, pack_xyz(100, 50, 50), pack_xyz(400, 0, 0),
        KIND_BOX, pack_xyz(256, 256, 256), pack_xyz(0, 0, 0), pack_xyz(-50, -3, 9)});
    // box A against sphere and box
    pending_pairs.push_back('{KIND_BOX, pack_xyz(0, 0, 0), pack_xyz(256, 256, 256),
        KIND_SPHERE, pack_xyz(300, 50, 50), pack_xyz(128, 0, 0), pack_xyz(1, 2, 3)});
    pending_pairs.push_back('{KIND_BOX, pack_xyz(0, 0, 0), pack_xyz(256, 256, 256),
        KIND_BOX, pack_xyz(256, 256, 256), pack_xyz(400, 400, 400), pack_xyz(-1, -2, -3)});
    pending_pairs.push_back('{KIND_BOX, pack_xyz(0, 0, 0), pack_xyz(256, 256, 256),
        KIND_BOX, pack_xyz(257, 0, 0), pack_xyz(400, 400, 400), pack_xyz(CMAX, CMIN, 0)});
    pending_pairs.push_back('{KIND_BOX, '1, '0, KIND_BOX, '0, '1, '1});
    pending_pairs.push_back('{KIND_SPHERE, '1, '1, KIND_SPHERE, '0, '0, '1});

    // let the pipe empty once before the random run
    wait_drained();

    for (int n = 0; n < 1050; n++) begin
      int sel;
      int span;
      sel = $urandom_range(0, 19);
      span = ($urandom_range(0, 9) == 0) ? int'(CMAX) : 1000;
      if (sel < 8) p = shaped_pair(KIND_SPHERE, KIND_SPHERE, span);
      else if (sel < 14) p = shaped_pair(KIND_SPHERE, KIND_BOX, span);
      else if (sel < 16) p = shaped_pair(KIND_BOX, KIND_SPHERE, span);
      else if (sel < 18) p = shaped_pair(KIND_BOX, KIND_BOX, span);
      else p = '{scbr_kind_e'($urandom_range(0, 1)), rand_wide(), rand_wide(),
                 scbr_kind_e'($urandom_range(0, 1)), rand_wide(), rand_wide(), rand_wide()};
      pending_pairs.push_back(p);
      if (n == 500) begin
        wait_drained();
      end
    end
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[sphere_box_collision_resolve_top] OK");
    end else begin
      $display("[sphere_box_collision_resolve_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[sphere_box_collision_resolve_top] ERROR");
    $finish;
  end

endmodule
